// ----- hdl/tccw_pkg.sv -----
// Shared types, constants and helpers for the text console cell writer.
package tccw_pkg;

    localparam int COLS     = 80;
    localparam int ROWS     = 25;
    localparam int CELLS    = COLS * ROWS;
    localparam int COL_W    = $clog2(COLS);
    localparam int ROW_W    = $clog2(ROWS);
    localparam int ROWN_W   = ROW_W + 1;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int SWP_W    = $clog2(CELLS + 1);
    localparam int CELL_W   = 16;
    localparam int CURSOR_W = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [7:0] DEFAULT_ATTR_RST = 8'h0f;
    localparam logic [7:0] ERROR_ATTR_RST   = 8'hf4;
    localparam logic [7:0] CHAR_NEWLINE     = 8'd10;
    localparam logic [7:0] CHAR_BACKSPACE   = 8'h08;
    localparam logic [7:0] CHAR_SPACE       = 8'h20;
    localparam logic [7:0] CHAR_ERROR       = 8'h45;

    localparam logic [2:0] REQ_PRINT_CUR = 3'd0;
    localparam logic [2:0] REQ_PRINT_POS = 3'd1;
    localparam logic [2:0] REQ_BACKSPACE = 3'd2;
    localparam logic [2:0] REQ_CLEAR     = 3'd3;
    localparam logic [2:0] REQ_READ      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ATTR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_ATTR   = 1'b1;

    localparam logic [1:0] SWP_ZERO   = 2'd0;
    localparam logic [1:0] SWP_SCROLL = 2'd1;
    localparam logic [1:0] SWP_CLEAR  = 2'd2;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] ch;
        logic [6:0] column;
        logic [4:0] line;
        logic [7:0] attr;
    } in_item_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_cell;
        logic [7:0]          cell_char;
        logic [7:0]          cell_attr;
        logic                coord_error;
    } out_item_t;

    typedef struct packed {
        logic       latch_req;
        logic       emit;
        logic       write_err;
        logic       rd_issue;
        logic       rd_capture;
        logic       cursor_zero;
        logic       sweep_run;
        logic [1:0] sweep_mode;
        logic       load_result;
    } ctl_cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       bad;
        logic       scroll;
        logic       sweep_last;
    } dp_stat_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(row) * ADDR_W'(COLS) + ADDR_W'(col);
    endfunction

endpackage

// ----- hdl/text_console_cell_writer.sv -----
// Top level of the text console cell writer: controller, datapath and checks.
// Sequence: a print, backspace or unknown request goes from EXEC to DONE, a valid cell read
// passes through RDWAIT, and a clear or a print that scrolls runs a sweep over the 2000-entry
// cell RAM, one cell per cycle; done is registered from DONE. One transaction at a time: the
// next is taken at the edge that ends the done cycle.
// Reset: the cursor and attributes take their reset values, then a sweep zeroes
// every cell with busy high; configuration writes are taken throughout.
// Results are strobed for one cycle on done; the receiver cannot stall.
module text_console_cell_writer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  tccw_pkg::in_item_t                req,
    output logic                              done,
    output tccw_pkg::out_item_t               result,
    input  logic                              cfg_we,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                        cfg_data
);

    import tccw_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    tccw_controller u_controller (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tccw_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe lasted more than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while a transaction is still in progress");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(result.cursor_cell) < CELLS))
        else $error("cursor beyond the last cell");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

endmodule

// ----- hdl/tccw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/tccw_datapath.sv -----
// Datapath: cell store, cursor, configuration registers, sweep counter and result register.
module tccw_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tccw_pkg::in_item_t                req,
    input  logic                              cfg_we,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                        cfg_data,
    input  tccw_pkg::ctl_cmd_t                cmd,
    output tccw_pkg::dp_stat_t                stat,
    output logic                              done,
    output tccw_pkg::out_item_t               result
);

    import tccw_pkg::*;

    in_item_t           req_reg;
    logic [7:0]         default_attr_reg;
    logic [7:0]         error_attr_reg;
    logic [ROW_W-1:0]   cur_row_reg;
    logic [COL_W-1:0]   cur_col_reg;
    logic [SWP_W-1:0]   cnt_reg;
    logic [CELL_W-1:0]  cell_data_reg;
    logic               done_reg;
    out_item_t          result_reg;

    logic               bad;
    logic               sweep_last;
    logic [ROW_W-1:0]   tr;
    logic [COL_W-1:0]   tc;
    logic [7:0]         ec;
    logic [7:0]         ea;
    logic               newline;
    logic [ROWN_W-1:0]  nr;
    logic [COL_W-1:0]   nc;
    logic               scroll;

    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [CELL_W-1:0]  wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
    logic [CELL_W-1:0]  rdata;

    assign bad = (32'(req_reg.column) >= COLS) || (32'(req_reg.line) >= ROWS);
    assign sweep_last = (cnt_reg == SWP_W'(CELLS));

    always_comb
    begin
        tr = cur_row_reg;
        tc = cur_col_reg;
        ec = req_reg.ch;
        ea = (req_reg.attr == 8'd0) ? default_attr_reg : req_reg.attr;
        if (req_reg.req_type == REQ_PRINT_POS)
        begin
            tr = ROW_W'(req_reg.line);
            tc = COL_W'(req_reg.column);
        end
        else if (req_reg.req_type == REQ_BACKSPACE)
        begin
            ec = CHAR_BACKSPACE;
            ea = default_attr_reg;
            if (cur_row_reg == '0 && cur_col_reg == '0)
            begin
                tr = '0;
                tc = '0;
            end
            else if (cur_col_reg == '0)
            begin
                tr = cur_row_reg - ROW_W'(1);
                tc = COL_W'(COLS - 1);
            end
            else
            begin
                tc = cur_col_reg - COL_W'(1);
            end
        end
        newline = (ec == CHAR_NEWLINE);
        if (newline || tc == COL_W'(COLS - 1))
        begin
            nr = ROWN_W'(tr) + ROWN_W'(1);
            nc = '0;
        end
        else
        begin
            nr = ROWN_W'(tr);
            nc = tc + COL_W'(1);
        end
        scroll = (nr == ROWN_W'(ROWS));
    end

    always_comb
    begin
        stat.req_type   = req_reg.req_type;
        stat.bad        = bad;
        stat.scroll     = scroll;
        stat.sweep_last = sweep_last;
    end

    // Write port: one printed cell, the error marker, or the trailing sweep write.
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (cmd.emit)
        begin
            we    = !newline;
            waddr = cell_addr(tr, tc);
            wdata = {ea, ec};
        end
        else if (cmd.write_err)
        begin
            we    = 1'b1;
            waddr = ADDR_W'(CELLS - 1);
            wdata = {error_attr_reg, CHAR_ERROR};
        end
        else if (cmd.sweep_run && cnt_reg != '0)
        begin
            we    = 1'b1;
            waddr = ADDR_W'(cnt_reg - SWP_W'(1));
            case (cmd.sweep_mode)
                SWP_SCROLL: wdata = (cnt_reg <= SWP_W'(CELLS - COLS)) ? rdata : '0;
                SWP_CLEAR:  wdata = {rdata[CELL_W-1:8], CHAR_SPACE};
                default:    wdata = '0;
            endcase
        end
    end

    always_comb
    begin
        re    = 1'b0;
        raddr = '0;
        if (cmd.rd_issue)
        begin
            re    = 1'b1;
            raddr = cell_addr(ROW_W'(req_reg.line), COL_W'(req_reg.column));
        end
        else if (cmd.sweep_run)
        begin
            case (cmd.sweep_mode)
                SWP_SCROLL:
                begin
                    re    = (cnt_reg < SWP_W'(CELLS - COLS));
                    raddr = ADDR_W'(cnt_reg + SWP_W'(COLS));
                end
                SWP_CLEAR:
                begin
                    re    = (cnt_reg < SWP_W'(CELLS));
                    raddr = ADDR_W'(cnt_reg);
                end
                default:
                begin
                    re    = 1'b0;
                    raddr = '0;
                end
            endcase
        end
    end

    tccw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_attr_reg <= DEFAULT_ATTR_RST;
            error_attr_reg   <= ERROR_ATTR_RST;
            cur_row_reg      <= '0;
            cur_col_reg      <= '0;
            cnt_reg          <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_DEFAULT_ATTR)
                begin
                    default_attr_reg <= cfg_data;
                end
                else if (cfg_index == REG_ERROR_ATTR)
                begin
                    error_attr_reg <= cfg_data;
                end
            end
            if (cmd.emit)
            begin
                cur_row_reg <= scroll ? ROW_W'(ROWS - 1) : ROW_W'(nr);
                cur_col_reg <= nc;
            end
            else if (cmd.cursor_zero)
            begin
                cur_row_reg <= '0;
                cur_col_reg <= '0;
            end
            if (cmd.sweep_run)
            begin
                cnt_reg <= sweep_last ? '0 : cnt_reg + SWP_W'(1);
            end
            done_reg <= cmd.load_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_reg       <= req;
            cell_data_reg <= '0;
        end
        else if (cmd.rd_capture)
        begin
            cell_data_reg <= rdata;
        end
        if (cmd.load_result)
        begin
            result_reg.cursor_cell <= CURSOR_W'(cell_addr(cur_row_reg, cur_col_reg));
            result_reg.cell_char   <= cell_data_reg[7:0];
            result_reg.cell_attr   <= cell_data_reg[CELL_W-1:8];
            result_reg.coord_error <= bad && (req_reg.req_type == REQ_PRINT_POS ||
                                              req_reg.req_type == REQ_READ);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- hdl/tccw_controller.sv -----
// Controller state machine: sequences each transaction and the store sweeps.
module tccw_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  tccw_pkg::dp_stat_t   stat,
    output tccw_pkg::ctl_cmd_t   cmd,
    output logic                 busy
);

    import tccw_pkg::*;

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_RDWAIT = 3'd3;
    localparam logic [2:0] ST_SCROLL = 3'd4;
    localparam logic [2:0] ST_CLEAR  = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_run  = 1'b1;
                cmd.sweep_mode = SWP_ZERO;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch_req = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                unique case (stat.req_type) inside
                    REQ_PRINT_CUR, REQ_BACKSPACE:
                    begin
                        cmd.emit = 1'b1;
                        if (stat.scroll)
                        begin
                            state_next = ST_SCROLL;
                        end
                    end
                    REQ_PRINT_POS:
                    begin
                        if (stat.bad)
                        begin
                            cmd.write_err = 1'b1;
                        end
                        else
                        begin
                            cmd.emit = 1'b1;
                            if (stat.scroll)
                            begin
                                state_next = ST_SCROLL;
                            end
                        end
                    end
                    REQ_CLEAR:
                    begin
                        cmd.cursor_zero = 1'b1;
                        state_next      = ST_CLEAR;
                    end
                    REQ_READ:
                    begin
                        if (!stat.bad)
                        begin
                            cmd.rd_issue = 1'b1;
                            state_next   = ST_RDWAIT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_RDWAIT:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = ST_DONE;
            end
            ST_SCROLL:
            begin
                cmd.sweep_run  = 1'b1;
                cmd.sweep_mode = SWP_SCROLL;
                if (stat.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CLEAR:
            begin
                cmd.sweep_run  = 1'b1;
                cmd.sweep_mode = SWP_CLEAR;
                if (stat.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cmd.load_result = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule
